/* sv/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg: shared definitions for the text console writer
// Screen geometry, field widths, character codes, operation codes and the
// command and status types that join the controller to the datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

	// Screen geometry
	localparam int COLS     = 80;
	localparam int ROWS     = 25;
	localparam int CELLS    = COLS * ROWS;
	localparam int COPY_END = CELLS - COLS;

	// Internal widths follow the geometry
	localparam int ADDR_W = $clog2(CELLS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int COL_W  = $clog2(COLS);

	// Fixed field widths of the stream payload
	localparam int FUNC_W     = 2;
	localparam int CHAR_W     = 8;
	localparam int IDX_W      = 11;
	localparam int ENTRY_W    = 16;
	localparam int ROW_OUT_W  = 5;
	localparam int COL_OUT_W  = 7;
	localparam int COLOR_W    = 4;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 32;
	localparam int OUT_PAD_W  = OUT_DATA_W - ENTRY_W - ROW_OUT_W - COL_OUT_W;

	// Character codes
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

	// Colour reset values and the blank cell left by reset
	localparam logic [COLOR_W-1:0] FG_RESET = 4'hB;
	localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;
	localparam logic [ENTRY_W-1:0] RESET_BLANK = {BG_RESET, FG_RESET, CH_SPACE};

	// Configuration register indexes
	localparam logic CFG_FG = 1'b0;
	localparam logic CFG_BG = 1'b1;

	// Operation codes carried on the input tuser
	typedef enum logic [FUNC_W-1:0] {
		FUNC_PUT   = 2'd0,
		FUNC_CLEAR = 2'd1,
		FUNC_READ  = 2'd2
	} func_t;

	// Datapath commands issued by the controller
	typedef enum logic [3:0] {
		DP_HOLD,
		DP_ACCEPT,
		DP_GLYPH,
		DP_NEWLINE,
		DP_BACKSPACE,
		DP_CLEAR,
		DP_READ,
		DP_TAKE,
		DP_SCROLL,
		DP_FILL,
		DP_INIT
	} dp_op_t;

	// Datapath status seen by the controller
	typedef struct packed {
		logic is_newline;
		logic is_backspace;
		logic col_zero;
		logic col_last;
		logic row_last;
		logic idx_ok;
		logic copy_end;
		logic fill_end;
	} dp_status_t;

endpackage

/* sv/tcw_datapath.sv */
// ----------------------------------------------------------------------------
// tcw_datapath: screen store, cursor and colour registers
// Holds the cell memory with one write and one registered read port, the
// cursor, the sweep counter used by clear, scroll and the reset pass, and the
// result entry register. Acts on one command from the controller each cycle.
// ----------------------------------------------------------------------------
module tcw_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [tcw_pkg::COLOR_W-1:0]       cfg_wdata,
	input  tcw_pkg::dp_op_t                   op,
	input  logic [tcw_pkg::CHAR_W-1:0]        char_code,
	input  logic [tcw_pkg::IDX_W-1:0]         cell_index,
	output tcw_pkg::dp_status_t               status,
	output logic [tcw_pkg::ENTRY_W-1:0]       cell_entry,
	output logic [tcw_pkg::ROW_OUT_W-1:0]     pos_row,
	output logic [tcw_pkg::COL_OUT_W-1:0]     pos_col
);

	logic [tcw_pkg::COLOR_W-1:0] fg_q;
	logic [tcw_pkg::COLOR_W-1:0] bg_q;
	logic [tcw_pkg::ROW_W-1:0]   row_q;
	logic [tcw_pkg::COL_W-1:0]   col_q;
	logic [tcw_pkg::ADDR_W-1:0]  rowbase_q;
	logic [tcw_pkg::ADDR_W-1:0]  cnt_q;
	logic [tcw_pkg::ENTRY_W-1:0] entry_q;
	logic [tcw_pkg::ENTRY_W-1:0] rdata_q;
	logic [tcw_pkg::ENTRY_W-1:0] store_mem [tcw_pkg::CELLS];

	logic [tcw_pkg::ENTRY_W-1:0] blank;
	logic [tcw_pkg::ENTRY_W-1:0] glyph;
	logic [tcw_pkg::COL_W-1:0]   col_dec;
	logic [tcw_pkg::ADDR_W-1:0]  cur_addr;
	logic [tcw_pkg::ADDR_W-1:0]  bs_addr;
	logic                        wr_en;
	logic [tcw_pkg::ADDR_W-1:0]  wr_addr;
	logic [tcw_pkg::ENTRY_W-1:0] wr_data;
	logic                        rd_en;
	logic [tcw_pkg::ADDR_W-1:0]  rd_addr;

	// Build cell values and cursor addresses
	assign blank    = {bg_q, fg_q, tcw_pkg::CH_SPACE};
	assign glyph    = {bg_q, fg_q, char_code};
	assign col_dec  = col_q - tcw_pkg::COL_W'(1);
	assign cur_addr = rowbase_q + tcw_pkg::ADDR_W'(col_q);
	assign bs_addr  = rowbase_q + tcw_pkg::ADDR_W'(col_dec);

	// Report status to the controller
	assign status.is_newline   = (char_code == tcw_pkg::CH_NEWLINE);
	assign status.is_backspace = (char_code == tcw_pkg::CH_BACKSPACE);
	assign status.col_zero     = (col_q == '0);
	assign status.col_last     = (col_q == tcw_pkg::COL_W'(tcw_pkg::COLS - 1));
	assign status.row_last     = (row_q == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));
	assign status.idx_ok       = (cell_index < tcw_pkg::IDX_W'(tcw_pkg::CELLS));
	assign status.copy_end     = (cnt_q == tcw_pkg::ADDR_W'(tcw_pkg::COPY_END));
	assign status.fill_end     = (cnt_q == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1));

	// Steer the memory ports
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cur_addr;
		wr_data = glyph;
		rd_en   = 1'b0;
		rd_addr = tcw_pkg::ADDR_W'(cell_index);
		unique case (op)
			tcw_pkg::DP_GLYPH: begin
				wr_en = 1'b1;
			end
			tcw_pkg::DP_BACKSPACE: begin
				wr_en   = !status.col_zero;
				wr_addr = bs_addr;
				wr_data = blank;
			end
			tcw_pkg::DP_READ: begin
				rd_en = 1'b1;
			end
			tcw_pkg::DP_SCROLL: begin
				// read one row ahead, write back what was read last cycle
				rd_en   = !status.copy_end;
				rd_addr = cnt_q + tcw_pkg::ADDR_W'(tcw_pkg::COLS);
				wr_en   = (cnt_q != '0);
				wr_addr = cnt_q - tcw_pkg::ADDR_W'(1);
				wr_data = rdata_q;
			end
			tcw_pkg::DP_FILL: begin
				wr_en   = 1'b1;
				wr_addr = cnt_q;
				wr_data = blank;
			end
			tcw_pkg::DP_INIT: begin
				wr_en   = 1'b1;
				wr_addr = cnt_q;
				wr_data = tcw_pkg::RESET_BLANK;
			end
			default: begin
			end
		endcase
	end

	// Screen store with registered read data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= store_mem[rd_addr];
		end
	end

	// Hold the colour registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= tcw_pkg::FG_RESET;
			bg_q <= tcw_pkg::BG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tcw_pkg::CFG_FG: fg_q <= cfg_wdata;
				tcw_pkg::CFG_BG: bg_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Advance the cursor and the sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q     <= '0;
			col_q     <= '0;
			rowbase_q <= '0;
			cnt_q     <= '0;
		end else begin
			unique case (op)
				tcw_pkg::DP_GLYPH: begin
					cnt_q <= '0;
					if (status.col_last) begin
						col_q <= '0;
						if (!status.row_last) begin
							row_q     <= row_q + tcw_pkg::ROW_W'(1);
							rowbase_q <= rowbase_q + tcw_pkg::ADDR_W'(tcw_pkg::COLS);
						end
					end else begin
						col_q <= col_q + tcw_pkg::COL_W'(1);
					end
				end
				tcw_pkg::DP_NEWLINE: begin
					cnt_q <= '0;
					col_q <= '0;
					if (!status.row_last) begin
						row_q     <= row_q + tcw_pkg::ROW_W'(1);
						rowbase_q <= rowbase_q + tcw_pkg::ADDR_W'(tcw_pkg::COLS);
					end
				end
				tcw_pkg::DP_BACKSPACE: begin
					if (!status.col_zero) begin
						col_q <= col_dec;
					end
				end
				tcw_pkg::DP_CLEAR: begin
					row_q     <= '0;
					col_q     <= '0;
					rowbase_q <= '0;
					cnt_q     <= '0;
				end
				tcw_pkg::DP_SCROLL: begin
					// stop on the first cell of the bottom row, ready for the blank fill
					if (!status.copy_end) begin
						cnt_q <= cnt_q + tcw_pkg::ADDR_W'(1);
					end
				end
				tcw_pkg::DP_FILL, tcw_pkg::DP_INIT: begin
					cnt_q <= cnt_q + tcw_pkg::ADDR_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// Load the result entry: zero on every transaction, the cell for a read
	always_ff @(posedge clk) begin
		unique case (op)
			tcw_pkg::DP_ACCEPT, tcw_pkg::DP_GLYPH, tcw_pkg::DP_NEWLINE,
			tcw_pkg::DP_BACKSPACE, tcw_pkg::DP_CLEAR, tcw_pkg::DP_READ: begin
				entry_q <= '0;
			end
			tcw_pkg::DP_TAKE: begin
				entry_q <= rdata_q;
			end
			default: begin
			end
		endcase
	end

	assign cell_entry = entry_q;
	assign pos_row    = tcw_pkg::ROW_OUT_W'(row_q);
	assign pos_col    = tcw_pkg::COL_OUT_W'(col_q);

endmodule

/* sv/tcw_ctrl.sv */
// ----------------------------------------------------------------------------
// tcw_ctrl: controller for the text console writer
// Decodes each input transaction into datapath commands, sequences the reset
// pass, clear, scroll and read, and owns the result valid flag.
// ----------------------------------------------------------------------------
module tcw_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [tcw_pkg::FUNC_W-1:0]  func,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	input  tcw_pkg::dp_status_t         status,
	output tcw_pkg::dp_op_t             op
);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_SCROLL,
		ST_FILL
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   accept;
	logic   done;

	// Take a transaction only when idle and the result slot is free or freeing
	assign s_tready = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;

	// Decode commands and next state
	always_comb begin
		op        = tcw_pkg::DP_HOLD;
		state_nxt = state_q;
		done      = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				op = tcw_pkg::DP_INIT;
				if (status.fill_end) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					case (tcw_pkg::func_t'(func))
						tcw_pkg::FUNC_PUT: begin
							priority if (status.is_newline) begin
								op = tcw_pkg::DP_NEWLINE;
								if (status.row_last) begin
									state_nxt = ST_SCROLL;
								end else begin
									done = 1'b1;
								end
							end else if (status.is_backspace) begin
								op   = tcw_pkg::DP_BACKSPACE;
								done = 1'b1;
							end else begin
								op = tcw_pkg::DP_GLYPH;
								if (status.col_last && status.row_last) begin
									state_nxt = ST_SCROLL;
								end else begin
									done = 1'b1;
								end
							end
						end
						tcw_pkg::FUNC_CLEAR: begin
							op        = tcw_pkg::DP_CLEAR;
							state_nxt = ST_FILL;
						end
						tcw_pkg::FUNC_READ: begin
							if (status.idx_ok) begin
								op        = tcw_pkg::DP_READ;
								state_nxt = ST_READ;
							end else begin
								op   = tcw_pkg::DP_ACCEPT;
								done = 1'b1;
							end
						end
						default: begin
							op   = tcw_pkg::DP_ACCEPT;
							done = 1'b1;
						end
					endcase
				end
			end
			ST_READ: begin
				op        = tcw_pkg::DP_TAKE;
				done      = 1'b1;
				state_nxt = ST_IDLE;
			end
			ST_SCROLL: begin
				op = tcw_pkg::DP_SCROLL;
				if (status.copy_end) begin
					state_nxt = ST_FILL;
				end
			end
			ST_FILL: begin
				op = tcw_pkg::DP_FILL;
				if (status.fill_end) begin
					done      = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Hold state and the result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* sv/text_console_writer.sv */
// ----------------------------------------------------------------------------
// text_console_writer: 80x25 text-mode console
// Character cell store with cursor, put / clear / read operations.
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole store to blanks (space, attribute
// 0x0B), one cell a cycle, so s_tready stays low for the whole sweep; colour
// writes are taken during that time. A put of a glyph, backspace or newline
// that does not scroll, a read past the end of the store, and an unused
// operation code finish in the cycle they are accepted, so such transactions
// can follow one per cycle while m_tready is high. A read inside the store
// passes through a read state, as the cell memory has a registered read port.
// A clear resets the cursor in the accepting cycle, then makes one memory
// write per cell. A put that moves past the last row scrolls through the
// single memory read and write port: it copies rows up, then blanks the
// bottom row, after the accepting cycle. One transaction is in work at a
// time; its result sits in an output register until taken.
// ----------------------------------------------------------------------------
module text_console_writer (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration
	input  logic                               cfg_we,
	input  logic                               cfg_index,
	input  logic [tcw_pkg::COLOR_W-1:0]        cfg_wdata,
	// input stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [tcw_pkg::IN_DATA_W-1:0]      s_tdata,   // char_code[7:0], cell_index[18:8]
	input  logic [tcw_pkg::FUNC_W-1:0]         s_tuser,   // func[1:0]
	// output stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [tcw_pkg::OUT_DATA_W-1:0]     m_tdata    // cell_entry[15:0],
	                                                      // cursor_row_out[20:16],
	                                                      // cursor_col_out[27:21]
);

	tcw_pkg::dp_op_t                 op;
	tcw_pkg::dp_status_t             status;
	logic [tcw_pkg::CHAR_W-1:0]      char_code;
	logic [tcw_pkg::IDX_W-1:0]       cell_index;
	logic [tcw_pkg::ENTRY_W-1:0]     cell_entry;
	logic [tcw_pkg::ROW_OUT_W-1:0]   pos_row;
	logic [tcw_pkg::COL_OUT_W-1:0]   pos_col;

	// Unpack the input payload
	assign char_code  = s_tdata[tcw_pkg::CHAR_W-1:0];
	assign cell_index = s_tdata[tcw_pkg::CHAR_W +: tcw_pkg::IDX_W];

	tcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.func     (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.op       (op)
	);

	tcw_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.op         (op),
		.char_code  (char_code),
		.cell_index (cell_index),
		.status     (status),
		.cell_entry (cell_entry),
		.pos_row    (pos_row),
		.pos_col    (pos_col)
	);

	// Pack the result payload
	assign m_tdata = {{tcw_pkg::OUT_PAD_W{1'b0}}, pos_col, pos_row, cell_entry};

	// A transaction is never taken while an untaken result is held
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> (!m_tvalid || m_tready))
		else $error("input taken while result pending");

	// Reported cursor stays on the screen
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[20:16] < tcw_pkg::ROW_OUT_W'(tcw_pkg::ROWS))
			&& (m_tdata[27:21] < tcw_pkg::COL_OUT_W'(tcw_pkg::COLS))))
		else $error("cursor outside screen");

	// A clear sweeps the store, so the input stalls on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == tcw_pkg::FUNC_CLEAR)) |=> !s_tready)
		else $error("input taken during clear");

	// An in-range read passes through the read state with m_tvalid low, then delivers its result
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == tcw_pkg::FUNC_READ)
			&& (s_tdata[18:8] < tcw_pkg::IDX_W'(tcw_pkg::CELLS)))
		|=> !m_tvalid ##1 m_tvalid)
		else $error("read result not delivered on time");

endmodule

/* tb/text_console_writer_test.sv */
// ----------------------------------------------------------------------------
// text_console_writer_test: self-checking bench for the text console writer
// Streams put / clear / read / unused commands into the console and checks
// every status transaction against an in-bench model of the screen store and
// cursor. Colours change only while the console is idle. Both stream sides
// idle at random.
// ----------------------------------------------------------------------------
module text_console_writer_test;
	timeunit 1ns;
	timeprecision 1ps;

	// Operation code the package leaves unassigned
	localparam logic [tcw_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int unsigned RANDOM_PER_PHASE = 230;

	typedef struct packed {
		logic [tcw_pkg::FUNC_W-1:0] func;
		logic [tcw_pkg::CHAR_W-1:0] code;
		logic [tcw_pkg::IDX_W-1:0]  idx;
	} console_cmd_t;

	typedef struct packed {
		logic [tcw_pkg::ENTRY_W-1:0]   entry;
		logic [tcw_pkg::ROW_OUT_W-1:0] row;
		logic [tcw_pkg::COL_OUT_W-1:0] col;
	} console_view_t;

	logic                           clk;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic                           cfg_index = tcw_pkg::CFG_FG;
	logic [tcw_pkg::COLOR_W-1:0]    cfg_wdata = '0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [tcw_pkg::IN_DATA_W-1:0]  s_tdata = '0;   // char_code[7:0], cell_index[18:8]
	logic [tcw_pkg::FUNC_W-1:0]     s_tuser = '0;   // func[1:0]
	logic                           m_tvalid;
	logic                           m_tready = 1'b1;
	logic [tcw_pkg::OUT_DATA_W-1:0] m_tdata;        // cell_entry[15:0],
	                                                // cursor_row_out[20:16],
	                                                // cursor_col_out[27:21]

	// Model state: screen, cursor and colours
	logic [tcw_pkg::ENTRY_W-1:0] console_cells [tcw_pkg::CELLS];
	int unsigned                 cur_row;
	int unsigned                 cur_col;
	logic [tcw_pkg::COLOR_W-1:0] fg_shadow;
	logic [tcw_pkg::COLOR_W-1:0] bg_shadow;

	console_cmd_t  cmd_backlog[$];
	console_view_t awaited_status[$];
	int unsigned   queued_items;
	int unsigned   send_gap;
	int unsigned   stall_left;
	int unsigned   fail_count;
	bit            calm_phase;

	text_console_writer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Clock and reset
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Watchdog
	initial begin
		#200_000_000;
		$display("[text_console_writer] ERROR");
		$finish;
	end

	// Idle length: mostly none, some short, a few long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm_phase || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic logic [tcw_pkg::ENTRY_W-1:0] blank_cell();
		return {bg_shadow, fg_shadow, tcw_pkg::CH_SPACE};
	endfunction

	// Advance the cursor row, scrolling the screen up past the last row
	function automatic void next_row();
		int unsigned i;
		cur_row++;
		if (cur_row >= tcw_pkg::ROWS) begin
			for (i = 0; i < tcw_pkg::CELLS - tcw_pkg::COLS; i++)
				console_cells[tcw_pkg::ADDR_W'(i)] =
					console_cells[tcw_pkg::ADDR_W'(i + tcw_pkg::COLS)];
			for (i = tcw_pkg::CELLS - tcw_pkg::COLS; i < tcw_pkg::CELLS; i++)
				console_cells[tcw_pkg::ADDR_W'(i)] = blank_cell();
			cur_row = tcw_pkg::ROWS - 1;
		end
	endfunction

	// Apply one command to the model and return the status it reports
	function automatic console_view_t console_apply(console_cmd_t c);
		console_view_t v;
		int unsigned   i;
		v.entry = '0;
		case (c.func)
			tcw_pkg::FUNC_PUT: begin
				if (c.code == tcw_pkg::CH_NEWLINE) begin
					cur_col = 0;
					next_row();
				end else if (c.code == tcw_pkg::CH_BACKSPACE) begin
					if (cur_col > 0) begin
						cur_col--;
						console_cells[tcw_pkg::ADDR_W'(cur_row * tcw_pkg::COLS + cur_col)] =
							blank_cell();
					end
				end else begin
					console_cells[tcw_pkg::ADDR_W'(cur_row * tcw_pkg::COLS + cur_col)] =
						{bg_shadow, fg_shadow, c.code};
					cur_col++;
					if (cur_col >= tcw_pkg::COLS) begin
						cur_col = 0;
						next_row();
					end
				end
			end
			tcw_pkg::FUNC_CLEAR: begin
				for (i = 0; i < tcw_pkg::CELLS; i++)
					console_cells[tcw_pkg::ADDR_W'(i)] = blank_cell();
				cur_row = 0;
				cur_col = 0;
			end
			tcw_pkg::FUNC_READ: begin
				if (c.idx < tcw_pkg::CELLS)
					v.entry = console_cells[c.idx];
			end
			default: begin
			end
		endcase
		v.row = cur_row[tcw_pkg::ROW_OUT_W-1:0];
		v.col = cur_col[tcw_pkg::COL_OUT_W-1:0];
		return v;
	endfunction

	// Drive commands; predict each one as it is accepted
	always @(posedge clk or negedge arst_n) begin : cmd_driver
		console_cmd_t c;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
			send_gap <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) begin
				c.func = s_tuser;
				c.code = s_tdata[tcw_pkg::CHAR_W-1:0];
				c.idx  = s_tdata[tcw_pkg::CHAR_W+tcw_pkg::IDX_W-1:tcw_pkg::CHAR_W];
				awaited_status.push_back(console_apply(c));
			end
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				s_tvalid <= 1'b0;
			end else if (cmd_backlog.size() > 0) begin
				c = cmd_backlog.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {{(tcw_pkg::IN_DATA_W - tcw_pkg::IDX_W - tcw_pkg::CHAR_W){1'b0}},
					c.idx, c.code};
				s_tuser  <= c.func;
				send_gap <= pick_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	task automatic flag_mismatch(string field, int unsigned want, int unsigned got);
		fail_count++;
		$display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
	endtask

	// Take status transactions with random stalls and check them in order
	always @(posedge clk or negedge arst_n) begin : status_monitor
		console_view_t want;
		console_view_t got;
		int unsigned   g;
		if (!arst_n) begin
			m_tready   <= 1'b1;
			stall_left <= 0;
		end else if (m_tvalid && m_tready) begin
			got.entry = m_tdata[tcw_pkg::ENTRY_W-1:0];
			got.row   = m_tdata[tcw_pkg::ENTRY_W+tcw_pkg::ROW_OUT_W-1:tcw_pkg::ENTRY_W];
			got.col   = m_tdata[tcw_pkg::ENTRY_W+tcw_pkg::ROW_OUT_W+tcw_pkg::COL_OUT_W-1:
				tcw_pkg::ENTRY_W+tcw_pkg::ROW_OUT_W];
			if (awaited_status.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected status, expected none actual %h", $time, got);
			end else begin
				want = awaited_status.pop_front();
				if (got.entry !== want.entry)
					flag_mismatch("cell_entry", 32'(want.entry), 32'(got.entry));
				if (got.row !== want.row)
					flag_mismatch("cursor_row_out", 32'(want.row), 32'(got.row));
				if (got.col !== want.col)
					flag_mismatch("cursor_col_out", 32'(want.col), 32'(got.col));
			end
			g = pick_gap();
			if (g > 0) begin
				m_tready   <= 1'b0;
				stall_left <= g;
			end
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			if (stall_left == 1)
				m_tready <= 1'b1;
		end
	end

	task automatic push_cmd(logic [tcw_pkg::FUNC_W-1:0] func,
			logic [tcw_pkg::CHAR_W-1:0] code, logic [tcw_pkg::IDX_W-1:0] idx);
		console_cmd_t c;
		c.func = func;
		c.code = code;
		c.idx  = idx;
		cmd_backlog.push_back(c);
		if (func != FUNC_UNUSED)
			queued_items++;
	endtask

	// Hold until every command has gone and every status has come back
	task automatic drain();
		do
			@(negedge clk);
		while (cmd_backlog.size() != 0 || awaited_status.size() != 0 || s_tvalid);
	endtask

	task automatic write_colour(logic idx, logic [tcw_pkg::COLOR_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == tcw_pkg::CFG_FG)
			fg_shadow = value;
		else
			bg_shadow = value;
	endtask

	function automatic logic [tcw_pkg::IDX_W-1:0] pick_cell();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return tcw_pkg::IDX_W'($urandom_range(0, tcw_pkg::CELLS - 1));
		if (r < 6)
			return tcw_pkg::IDX_W'($urandom_range(0, 3 * tcw_pkg::COLS - 1));
		if (r < 8)
			return tcw_pkg::IDX_W'($urandom_range(tcw_pkg::CELLS - 2 * tcw_pkg::COLS,
				tcw_pkg::CELLS - 1));
		if (r < 9)
			return tcw_pkg::IDX_W'(tcw_pkg::CELLS - 1);
		return tcw_pkg::IDX_W'($urandom_range(tcw_pkg::CELLS, (1 << tcw_pkg::IDX_W) - 1));
	endfunction

	function automatic logic [tcw_pkg::CHAR_W-1:0] any_code();
		return tcw_pkg::CHAR_W'($urandom_range(0, 255));
	endfunction

	function automatic logic [tcw_pkg::IDX_W-1:0] any_idx();
		return tcw_pkg::IDX_W'($urandom_range(0, 2047));
	endfunction

	// Mostly text lines with backspaces, some reads, a few clears and noise
	task automatic queue_random(int unsigned n);
		int unsigned target;
		int unsigned r;
		int unsigned len;
		int unsigned k;
		target = queued_items + n;
		while (queued_items < target) begin
			r = $urandom_range(0, 99);
			if (r < 4) begin
				push_cmd(tcw_pkg::FUNC_CLEAR, any_code(), any_idx());
			end else if (r < 7) begin
				push_cmd(FUNC_UNUSED, any_code(), any_idx());
			end else if (r < 25) begin
				push_cmd(tcw_pkg::FUNC_READ, any_code(), pick_cell());
			end else begin
				if ($urandom_range(0, 9) == 0)
					len = $urandom_range(60, 170);
				else
					len = $urandom_range(0, 25);
				for (k = 0; k < len; k++) begin
					if ($urandom_range(0, 11) == 0)
						push_cmd(tcw_pkg::FUNC_PUT, tcw_pkg::CH_BACKSPACE, any_idx());
					else
						push_cmd(tcw_pkg::FUNC_PUT, any_code(), any_idx());
				end
				if ($urandom_range(0, 5) != 0)
					push_cmd(tcw_pkg::FUNC_PUT, tcw_pkg::CH_NEWLINE, any_idx());
			end
		end
	endtask

	// Stimulus
	initial begin : stimulus
		int unsigned                 i;
		int unsigned                 p;
		logic [tcw_pkg::COLOR_W-1:0] fg;
		logic [tcw_pkg::COLOR_W-1:0] bg;

		fg_shadow  = tcw_pkg::FG_RESET;
		bg_shadow  = tcw_pkg::BG_RESET;
		cur_row    = 0;
		cur_col    = 0;
		fail_count = 0;
		calm_phase = 1'b0;
		queued_items = 0;
		for (i = 0; i < tcw_pkg::CELLS; i++)
			console_cells[tcw_pkg::ADDR_W'(i)] = blank_cell();

		// Directed: reset contents, store edges, reads past the end,
		// backspace at column zero, extreme bytes, unused code, clear
		push_cmd(tcw_pkg::FUNC_READ, 8'h00, tcw_pkg::IDX_W'(0));
		push_cmd(tcw_pkg::FUNC_READ, 8'hFF, tcw_pkg::IDX_W'(tcw_pkg::CELLS - 1));
		push_cmd(tcw_pkg::FUNC_READ, 8'h00, tcw_pkg::IDX_W'(tcw_pkg::CELLS));
		push_cmd(tcw_pkg::FUNC_READ, 8'h00, tcw_pkg::IDX_W'((1 << tcw_pkg::IDX_W) - 1));
		push_cmd(tcw_pkg::FUNC_PUT, tcw_pkg::CH_BACKSPACE, tcw_pkg::IDX_W'(0));
		push_cmd(tcw_pkg::FUNC_PUT, 8'h00, tcw_pkg::IDX_W'(0));
		push_cmd(tcw_pkg::FUNC_PUT, 8'hFF, tcw_pkg::IDX_W'((1 << tcw_pkg::IDX_W) - 1));
		push_cmd(tcw_pkg::FUNC_PUT, 8'h80, tcw_pkg::IDX_W'(0));
		push_cmd(tcw_pkg::FUNC_READ, 8'h00, tcw_pkg::IDX_W'(1));
		push_cmd(tcw_pkg::FUNC_READ, 8'h00, tcw_pkg::IDX_W'(2));
		push_cmd(tcw_pkg::FUNC_PUT, tcw_pkg::CH_BACKSPACE, tcw_pkg::IDX_W'(0));
		push_cmd(tcw_pkg::FUNC_READ, 8'h00, tcw_pkg::IDX_W'(2));
		push_cmd(tcw_pkg::FUNC_PUT, tcw_pkg::CH_NEWLINE, tcw_pkg::IDX_W'(0));
		push_cmd(FUNC_UNUSED, 8'hFF, tcw_pkg::IDX_W'((1 << tcw_pkg::IDX_W) - 1));
		push_cmd(tcw_pkg::FUNC_PUT, 8'h41, tcw_pkg::IDX_W'(0));
		push_cmd(tcw_pkg::FUNC_READ, 8'h00, tcw_pkg::IDX_W'(tcw_pkg::COLS));
		push_cmd(tcw_pkg::FUNC_CLEAR, 8'h00, tcw_pkg::IDX_W'(0));
		push_cmd(tcw_pkg::FUNC_READ, 8'h00, tcw_pkg::IDX_W'(0));
		push_cmd(tcw_pkg::FUNC_READ, 8'h00, tcw_pkg::IDX_W'(tcw_pkg::COLS));
		drain();

		// Random phases, each with its own colours set while idle
		for (p = 0; p < 6; p++) begin
			case (p)
				0: begin fg = 4'h0; bg = 4'h0; end
				1: begin fg = 4'hF; bg = 4'hF; end
				2: begin fg = 4'hF; bg = 4'h0; end
				3: begin fg = 4'h0; bg = 4'hF; end
				default: begin
					fg = tcw_pkg::COLOR_W'($urandom_range(0, 15));
					bg = tcw_pkg::COLOR_W'($urandom_range(0, 15));
				end
			endcase
			write_colour(tcw_pkg::CFG_FG, fg);
			write_colour(tcw_pkg::CFG_BG, bg);
			calm_phase = (p == 2);
			queue_random(RANDOM_PER_PHASE);
			drain();
		end

		// Let any stray transaction show up before the verdict
		repeat (2100) @(posedge clk);
		if (fail_count == 0)
			$display("[text_console_writer] OK");
		else
			$display("[text_console_writer] ERROR");
		$finish;
	end

endmodule
